[rtl/mtc_pkg.sv]
// Shared types, sizes and operation codes of the metatile atlas compositor.
package mtc_pkg;

  localparam int TILE_COUNT    = 1024;
  localparam int ATLAS_COLUMNS = 32;
  localparam int PALETTE_COUNT = 16;

  localparam int TILE_BYTES  = TILE_COUNT * 32;
  localparam int TILE_ID_W   = $clog2(TILE_COUNT);
  localparam int TILE_ADDR_W = TILE_ID_W + 5;
  localparam int PAL_ENTRIES = PALETTE_COUNT * 16;
  localparam int PAL_ID_W    = (PALETTE_COUNT > 1) ? $clog2(PALETTE_COUNT) : 1;
  localparam int PAL_ADDR_W  = PAL_ID_W + 4;

  // Reciprocal of the atlas width; exact for every 10-bit metatile index.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + ATLAS_COLUMNS - 1) / ATLAS_COLUMNS;

  localparam int LANES = 4;
  localparam int K_W   = 6;

  localparam logic [1:0] OP_TILE   = 2'd0;
  localparam logic [1:0] OP_PAL    = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] address;
    logic [14:0] value;
    logic [9:0]  metatile_index;
    logic [15:0] entry0;
    logic [15:0] entry1;
    logic [15:0] entry2;
    logic [15:0] entry3;
    logic [15:0] entry4;
    logic [15:0] entry5;
    logic [15:0] entry6;
    logic [15:0] entry7;
  } cmd_t;

  typedef struct packed {
    logic [23:0] pixel0;
    logic [23:0] pixel1;
    logic [23:0] pixel2;
    logic [23:0] pixel3;
    logic [8:0]  atlas_x;
    logic [8:0]  atlas_y;
    logic        last;
  } pix_t;

  typedef struct packed {
    logic        tile_we;
    logic        pal_we;
    logic [14:0] addr;
    logic [14:0] data;
  } wr_t;

  typedef struct packed {
    logic           valid;
    logic [K_W-1:0] k;
  } stage_t;

endpackage

[rtl/mtc_seq.sv]
// Command intake, store write decode and group sequencer with pipeline tracking.
module mtc_seq import mtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  input  logic       en,
  output wr_t        wr,
  output cmd_t       render,
  output stage_t     st0,
  output stage_t     st2,
  output logic [8:0] base_x,
  output logic [8:0] base_y
);

  logic           active;
  logic [K_W-1:0] cnt;
  stage_t         st1;
  stage_t         st2_q;
  logic [9:0]     quot;
  logic [30:0]    prod;
  logic [15:0]    qc;
  logic [15:0]    rem;
  logic           accept;

  assign cmd_ready = !active && !st1.valid && !st2_q.valid;
  assign accept    = cmd_valid && cmd_ready;

  assign wr.tile_we = accept && (cmd.op == OP_TILE) && ({1'b0, cmd.address} < 16'(TILE_BYTES));
  assign wr.pal_we  = accept && (cmd.op == OP_PAL) && ({1'b0, cmd.address} < 16'(PAL_ENTRIES));
  assign wr.addr    = cmd.address;
  assign wr.data    = cmd.value;

  assign prod = 31'(cmd.metatile_index) * 31'(RECIP);

  always_ff @(posedge clk) begin
    if (accept && cmd.op == OP_RENDER) begin
      render <= cmd;
      quot   <= prod[RECIP_SHIFT +: 10];
    end
  end

  assign qc     = 16'(quot) * 16'(ATLAS_COLUMNS);
  assign rem    = {6'd0, render.metatile_index} - qc;
  assign base_x = {rem[4:0], 4'd0};
  assign base_y = {quot[4:0], 4'd0};

  assign st0.valid = active;
  assign st0.k     = cnt;
  assign st2       = st2_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      cnt          <= '0;
      st1.valid    <= 1'b0;
      st2_q.valid  <= 1'b0;
    end else begin
      if (accept && cmd.op == OP_RENDER) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (en && active) begin
        cnt <= cnt + 1'b1;
        if (&cnt) active <= 1'b0;
      end
      if (en) begin
        st1.valid   <= active;
        st2_q.valid <= st1.valid;
      end
    end
  end

  // Group numbers follow the valid bits; no reset needed.
  always_ff @(posedge clk) begin
    if (en) begin
      st1.k   <= cnt;
      st2_q.k <= st1.k;
    end
  end

endmodule

[rtl/mtc_lane.sv]
// One pixel lane: private tile and palette copies, layer pick and color expand.
module mtc_lane import mtc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [1:0]  lane_id,
  input  wr_t         wr,
  input  cmd_t        render,
  input  stage_t      st0,
  output logic [23:0] color
);

  logic [7:0]  tile_mem [TILE_BYTES];
  logic [14:0] pal_mem  [PAL_ENTRIES];

  logic [3:0]  row;
  logic [3:0]  col;
  logic [1:0]  quad;
  logic [2:0]  x;
  logic [2:0]  y;
  logic [15:0] top_ent;
  logic [15:0] bot_ent;
  logic [2:0]  top_sx, top_sy, bot_sx, bot_sy;
  logic [TILE_ADDR_W-1:0] top_addr, bot_addr;

  logic [7:0]  top_byte, bot_byte;
  logic        top_hi, bot_hi;
  logic        top_ok, bot_ok;
  logic [3:0]  top_pal, bot_pal;

  logic [3:0]  ti, bi;
  logic [PAL_ADDR_W-1:0] pal_addr;
  logic        pal_ok;
  logic [14:0] pal_data;
  logic        pal_ok_q;
  logic [14:0] bgr;

  assign row  = st0.k[5:2];
  assign col  = {st0.k[1:0], lane_id};
  assign quad = {row[3], col[3]};
  assign x    = col[2:0];
  assign y    = row[2:0];

  always_comb begin
    case (quad)
      2'd0: begin bot_ent = render.entry0; top_ent = render.entry4; end
      2'd1: begin bot_ent = render.entry1; top_ent = render.entry5; end
      2'd2: begin bot_ent = render.entry2; top_ent = render.entry6; end
      2'd3: begin bot_ent = render.entry3; top_ent = render.entry7; end
      default: begin bot_ent = render.entry0; top_ent = render.entry4; end
    endcase
  end

  // A set flip bit mirrors the coordinate: 7 - x is ~x on three bits.
  assign top_sx = top_ent[10] ? ~x : x;
  assign top_sy = top_ent[11] ? ~y : y;
  assign bot_sx = bot_ent[10] ? ~x : x;
  assign bot_sy = bot_ent[11] ? ~y : y;

  assign top_addr = {top_ent[TILE_ID_W-1:0], top_sy, top_sx[2:1]};
  assign bot_addr = {bot_ent[TILE_ID_W-1:0], bot_sy, bot_sx[2:1]};

  always_ff @(posedge clk) begin
    if (wr.tile_we) tile_mem[wr.addr[TILE_ADDR_W-1:0]] <= wr.data[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_byte <= tile_mem[top_addr];
      bot_byte <= tile_mem[bot_addr];
      top_hi   <= top_sx[0];
      bot_hi   <= bot_sx[0];
      top_ok   <= {1'b0, top_ent[9:0]} < 11'(TILE_COUNT);
      bot_ok   <= {1'b0, bot_ent[9:0]} < 11'(TILE_COUNT);
      top_pal  <= top_ent[15:12];
      bot_pal  <= bot_ent[15:12];
    end
  end

  assign ti = !top_ok ? 4'd0 : (top_hi ? top_byte[7:4] : top_byte[3:0]);
  assign bi = !bot_ok ? 4'd0 : (bot_hi ? bot_byte[7:4] : bot_byte[3:0]);

  // Top wins on a nonzero index; a clear bottom falls back to palette entry 0.
  always_comb begin
    if (ti != 4'd0) begin
      pal_addr = {top_pal[PAL_ID_W-1:0], ti};
      pal_ok   = {1'b0, top_pal} < 5'(PALETTE_COUNT);
    end else if (bi == 4'd0) begin
      pal_addr = '0;
      pal_ok   = 1'b1;
    end else begin
      pal_addr = {bot_pal[PAL_ID_W-1:0], bi};
      pal_ok   = {1'b0, bot_pal} < 5'(PALETTE_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.pal_we) pal_mem[wr.addr[PAL_ADDR_W-1:0]] <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pal_data <= pal_mem[pal_addr];
      pal_ok_q <= pal_ok;
    end
  end

  assign bgr   = pal_ok_q ? pal_data : 15'd0;
  assign color = {bgr[14:10], 3'd0, bgr[9:5], 3'd0, bgr[4:0], 3'd0};

endmodule

[rtl/mtc_merge.sv]
// Output register: gathers the four lane colors into one item with its atlas position.
module mtc_merge import mtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  stage_t                st2,
  input  logic [8:0]            base_x,
  input  logic [8:0]            base_y,
  input  logic [LANES-1:0][23:0] colors,
  output logic                  en,
  output logic                  pix_valid,
  input  logic                  pix_ready,
  output pix_t                  pix
);

  // Advance the whole pipeline unless a finished item is still waiting.
  assign en = !pix_valid || pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (en) begin
      pix_valid <= st2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix.pixel0  <= colors[0];
      pix.pixel1  <= colors[1];
      pix.pixel2  <= colors[2];
      pix.pixel3  <= colors[3];
      pix.atlas_x <= base_x + {5'd0, st2.k[1:0], 2'd0};
      pix.atlas_y <= base_y + {5'd0, st2.k[5:2]};
      pix.last    <= &st2.k;
    end
  end

endmodule

[rtl/metatile_4bpp_atlas_compositor.sv]
// Load item: writes the tile or palette copies of all four lanes; no result.
// Render item: 64 results, one per cycle unless pix_ready holds the output (four pixel
// lanes, one group per cycle); the next item is accepted only once every group has left
// the sequencer. Each group passes the lane tile and palette reads and the output register.
// Synchronous active-high rst clears sequencer and valid bits; stores hold no reset.
module metatile_4bpp_atlas_compositor import mtc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic pix_valid,
  input  logic pix_ready,
  output pix_t pix
);

  logic                   en;
  wr_t                    wr;
  cmd_t                   render;
  stage_t                 st0;
  stage_t                 st2;
  logic [8:0]             base_x;
  logic [8:0]             base_y;
  logic [LANES-1:0][23:0] colors;

  mtc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .en        (en),
    .wr        (wr),
    .render    (render),
    .st0       (st0),
    .st2       (st2),
    .base_x    (base_x),
    .base_y    (base_y)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mtc_lane u_lane (
      .clk     (clk),
      .en      (en),
      .lane_id (2'(i)),
      .wr      (wr),
      .render  (render),
      .st0     (st0),
      .color   (colors[i])
    );
  end

  mtc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .st2       (st2),
    .base_x    (base_x),
    .base_y    (base_y),
    .colors    (colors),
    .en        (en),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

endmodule
